// ----- rtl/core/lattice_worm_soil_update_defines.svh -----
// assertion helpers shared by the lattice core modules
// both expect i_clk and i_rst_n in scope
`ifndef LATTICE_WORM_SOIL_UPDATE_DEFINES_SVH
`define LATTICE_WORM_SOIL_UPDATE_DEFINES_SVH

// same-cycle implication
`define LWSU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lwsu assertion failed");

// next-cycle implication
`define LWSU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lwsu assertion failed");

`endif

// ----- rtl/core/lwsu_pkg.sv -----
package lwsu_pkg;

    localparam int MAX_SIDE    = 512;
    localparam int SPECIES     = 3;
    localparam int PROB_BITS   = 16;

    localparam int COORD_W     = $clog2(MAX_SIDE);
    localparam int SIDE_W      = COORD_W + 1;
    localparam int ADDR_W      = 2 * COORD_W;
    localparam int CELL_W      = 3;
    localparam int PROB_W      = PROB_BITS + 1;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = PROB_W > SIDE_W ? PROB_W : SIDE_W;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CELL_W-1:0] CODE_EMPTY = CELL_W'(0);
    localparam logic [CELL_W-1:0] CODE_NUT0  = CELL_W'(1);
    localparam logic [CELL_W-1:0] CODE_SOIL  = CELL_W'(SPECIES + 1);
    localparam logic [CELL_W-1:0] CODE_WORM0 = CELL_W'(SPECIES + 2);
    localparam logic [CELL_W-1:0] CODE_WORMN = CELL_W'(2 * SPECIES + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_SIDE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FILL    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_DEATH   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_BREED   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_EXCRETE = CFG_IDX_W'(4);

    localparam logic [SIDE_W-1:0] SIDE_RESET    = SIDE_W'(500);
    localparam logic [PROB_W-1:0] FILL_RESET    = PROB_W'(32768);
    localparam logic [PROB_W-1:0] DEATH_RESET   = PROB_W'(1560);
    localparam logic [PROB_W-1:0] BREED_RESET   = PROB_W'(65536);
    localparam logic [PROB_W-1:0] EXCRETE_RESET = PROB_W'(65536);

    typedef enum logic [1:0] {
        KIND_WRITE  = 2'd0,
        KIND_READ   = 2'd1,
        KIND_UPDATE = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_FETCH,
        ST_EXEC,
        ST_NBRW
    } t_back_state;

    typedef struct packed {
        logic fill;
        logic death;
        logic breed;
        logic excrete;
    } t_pass;

    typedef struct packed {
        t_kind               kind;
        logic                bad;
        logic [ADDR_W-1:0]   site_addr;
        logic [ADDR_W-1:0]   nbr_addr;
        logic [CELL_W-1:0]   wval;
        t_pass               pass;
    } t_item;

    function automatic logic is_worm(input logic [CELL_W-1:0] c);
        return (c >= CODE_WORM0) && (c <= CODE_WORMN);
    endfunction

    // nutrient code eaten by worm c: species (k+1) mod SPECIES
    function automatic logic [CELL_W-1:0] prey_code(input logic [CELL_W-1:0] c);
        logic [CELL_W-1:0] k;
        k = c - CODE_WORM0;
        return (k == CELL_W'(SPECIES - 1)) ? CODE_NUT0 : k + CELL_W'(2);
    endfunction

    // nutrient left behind by worm c
    function automatic logic [CELL_W-1:0] dropping_code(input logic [CELL_W-1:0] c);
        return c - CODE_WORM0 + CODE_NUT0;
    endfunction

endpackage

// ----- rtl/core/lwsu_in_if.sv -----
interface lwsu_in_if;
    import lwsu_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [1:0]           kind;
    logic [COORD_W-1:0]   site_x;
    logic [COORD_W-1:0]   site_y;
    logic [CELL_W-1:0]    cell_value;
    logic                 nbr_axis;
    logic                 nbr_dir;
    logic [PROB_BITS-1:0] draw_first;
    logic [PROB_BITS-1:0] draw_second;

    modport source (
        output valid, kind, site_x, site_y, cell_value, nbr_axis, nbr_dir,
               draw_first, draw_second,
        input  ready
    );
    modport sink (
        input  valid, kind, site_x, site_y, cell_value, nbr_axis, nbr_dir,
               draw_first, draw_second,
        output ready
    );
endinterface

// ----- rtl/core/lwsu_out_if.sv -----
interface lwsu_out_if;
    import lwsu_pkg::*;

    logic              valid;
    logic              ready;
    logic [CELL_W-1:0] site_after;
    logic [CELL_W-1:0] neighbour_after;
    logic              bad_coordinate;

    modport source (
        output valid, site_after, neighbour_after, bad_coordinate,
        input  ready
    );
    modport sink (
        input  valid, site_after, neighbour_after, bad_coordinate,
        output ready
    );
endinterface

// ----- rtl/core/lwsu_front.sv -----
module lwsu_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lwsu_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lwsu_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    lwsu_in_if.sink                          i_in,
    input  logic                             i_q_ready,
    output logic                             o_push,
    output lwsu_pkg::t_item                  o_item
);
    import lwsu_pkg::*;

    logic [SIDE_W-1:0]  r_side;
    logic [PROB_W-1:0]  r_fill;
    logic [PROB_W-1:0]  r_death;
    logic [PROB_W-1:0]  r_breed;
    logic [PROB_W-1:0]  r_excrete;

    logic [SIDE_W-1:0]  side_eff;
    logic [COORD_W-1:0] side_m1;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] nx;
    logic [COORD_W-1:0] ny;
    logic [COORD_W-1:0] moved;
    logic [COORD_W-1:0] base;
    t_kind              kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side    <= SIDE_RESET;
            r_fill    <= FILL_RESET;
            r_death   <= DEATH_RESET;
            r_breed   <= BREED_RESET;
            r_excrete <= EXCRETE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SIDE:    r_side    <= i_cfg_data[SIDE_W-1:0];
                CFG_FILL:    r_fill    <= i_cfg_data[PROB_W-1:0];
                CFG_DEATH:   r_death   <= i_cfg_data[PROB_W-1:0];
                CFG_BREED:   r_breed   <= i_cfg_data[PROB_W-1:0];
                CFG_EXCRETE: r_excrete <= i_cfg_data[PROB_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        priority if (r_side < SIDE_W'(2))
            side_eff = SIDE_W'(2);
        else if (r_side > SIDE_W'(MAX_SIDE))
            side_eff = SIDE_W'(MAX_SIDE);
        else
            side_eff = r_side;
    end

    assign side_m1 = COORD_W'(side_eff - SIDE_W'(1));
    assign x       = i_in.site_x;
    assign y       = i_in.site_y;
    assign kind    = t_kind'(i_in.kind);

    // toroidal step along the chosen axis
    assign base  = i_in.nbr_axis ? y : x;
    assign moved = i_in.nbr_dir ? ((base == side_m1) ? '0 : base + COORD_W'(1))
                                : ((base == '0) ? side_m1 : base - COORD_W'(1));
    assign nx    = i_in.nbr_axis ? x : moved;
    assign ny    = i_in.nbr_axis ? moved : y;

    always_comb begin
        o_item.kind         = kind;
        o_item.bad          = (kind != KIND_NONE) &&
                              (({1'b0, x} >= side_eff) || ({1'b0, y} >= side_eff));
        o_item.site_addr    = {x, y};
        o_item.nbr_addr     = {nx, ny};
        o_item.wval         = i_in.cell_value;
        o_item.pass.fill    = {1'b0, i_in.draw_first}  < r_fill;
        o_item.pass.death   = {1'b0, i_in.draw_first}  < r_death;
        o_item.pass.breed   = {1'b0, i_in.draw_second} < r_breed;
        o_item.pass.excrete = {1'b0, i_in.draw_second} < r_excrete;
    end

    assign i_in.ready = i_q_ready;
    assign o_push     = i_in.valid && i_q_ready;

endmodule

// ----- rtl/core/lwsu_queue.sv -----
`include "lattice_worm_soil_update_defines.svh"

module lwsu_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lwsu_pkg::t_item  i_item,
    output logic             o_ready,
    output logic             o_valid,
    output lwsu_pkg::t_item  o_item,
    input  logic             i_pop
);
    import lwsu_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item              r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               push;
    logic               pop;

    assign o_ready = r_count != CNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_slot[r_rd_ptr];
    assign push    = i_push && o_ready;
    assign pop     = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (push && !pop)
            n_count = r_count + CNT_W'(1);
        else if (pop && !push)
            n_count = r_count - CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (push)
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            if (pop)
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push)
            r_slot[r_wr_ptr] <= i_item;
    end

    `LWSU_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CNT_W'(QUEUE_DEPTH))
    `LWSU_ASSERT_NXT(a_count_up, push && !pop, r_count == $past(r_count) + CNT_W'(1))
    `LWSU_ASSERT_NXT(a_count_down, pop && !push, r_count == $past(r_count) - CNT_W'(1))

endmodule

// ----- rtl/core/lwsu_back.sv -----
`include "lattice_worm_soil_update_defines.svh"

module lwsu_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  lwsu_pkg::t_item  i_item,
    output logic             o_pop,
    lwsu_out_if.source       o_out
);
    import lwsu_pkg::*;

    logic [CELL_W-1:0] r_lattice [MAX_SIDE * MAX_SIDE];

    t_back_state        r_state;
    t_back_state        n_state;
    t_item              r_item;
    logic [CELL_W-1:0]  r_rd_site;
    logic [CELL_W-1:0]  r_rd_nbr;
    logic [CELL_W-1:0]  r_nbr_wdata;
    logic               r_out_valid;
    logic [CELL_W-1:0]  r_site_after;
    logic [CELL_W-1:0]  r_nbr_after;
    logic               r_bad;

    logic               exec_go;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [CELL_W-1:0]  mem_wdata;
    logic [CELL_W-1:0]  site_new;
    logic [CELL_W-1:0]  nbr_new;
    logic               site_we;
    logic               nbr_we;

    // outcome of the item held in r_item
    always_comb begin
        site_new = '0;
        nbr_new  = '0;
        site_we  = 1'b0;
        nbr_we   = 1'b0;
        if (!r_item.bad) begin
            unique case (r_item.kind)
                KIND_WRITE: begin
                    site_new = r_item.wval;
                    site_we  = 1'b1;
                end
                KIND_READ: begin
                    site_new = r_rd_site;
                end
                KIND_UPDATE: begin
                    site_new = r_rd_site;
                    nbr_new  = r_rd_nbr;
                    if (r_rd_site <= CELL_W'(SPECIES)) begin
                        if (r_rd_nbr == CODE_SOIL && r_item.pass.fill) begin
                            site_new = CODE_SOIL;
                            site_we  = 1'b1;
                        end
                    end else if (is_worm(r_rd_site)) begin
                        site_new = CODE_EMPTY;
                        site_we  = 1'b1;
                        if (!r_item.pass.death) begin
                            nbr_new = r_rd_site;
                            nbr_we  = 1'b1;
                            priority if (r_rd_nbr == prey_code(r_rd_site)) begin
                                if (r_item.pass.breed)
                                    site_new = r_rd_site;
                            end else if (r_rd_nbr == CODE_SOIL) begin
                                if (r_item.pass.excrete)
                                    site_new = dropping_code(r_rd_site);
                            end else if (is_worm(r_rd_nbr)) begin
                                site_new = r_rd_nbr;
                            end
                        end
                    end
                end
                KIND_NONE: ;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state   = r_state;
        o_pop     = 1'b0;
        exec_go   = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_item.site_addr;
        mem_wdata = site_new;
        unique case (r_state)
            ST_FETCH: begin
                o_pop = i_valid;
                if (i_valid)
                    n_state = ST_EXEC;
            end
            ST_EXEC: begin
                exec_go = !r_out_valid || o_out.ready;
                if (exec_go) begin
                    mem_we  = site_we;
                    n_state = nbr_we ? ST_NBRW : ST_FETCH;
                end
            end
            ST_NBRW: begin
                mem_we    = 1'b1;
                mem_waddr = r_item.nbr_addr;
                mem_wdata = r_nbr_wdata;
                n_state   = ST_FETCH;
            end
            default: n_state = ST_FETCH;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= ST_FETCH;
        else
            r_state <= n_state;
    end

    // lattice: two registered reads when an item is taken, at most one write per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we)
            r_lattice[mem_waddr] <= mem_wdata;
        if (o_pop) begin
            r_rd_site <= r_lattice[i_item.site_addr];
            r_rd_nbr  <= r_lattice[i_item.nbr_addr];
            r_item    <= i_item;
        end
        if (exec_go)
            r_nbr_wdata <= nbr_new;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (exec_go)
            r_out_valid <= 1'b1;
        else if (o_out.ready)
            r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (exec_go) begin
            r_site_after <= site_new;
            r_nbr_after  <= nbr_new;
            r_bad        <= r_item.bad;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.site_after      = r_site_after;
    assign o_out.neighbour_after = r_nbr_after;
    assign o_out.bad_coordinate  = r_bad;

    `LWSU_ASSERT_IMP(a_nbrw_after_exec, r_state == ST_NBRW, $past(r_state) == ST_EXEC)
    `LWSU_ASSERT_NXT(a_exec_loads_out, exec_go, r_out_valid)
    `LWSU_ASSERT_IMP(a_bad_no_write, r_state == ST_EXEC && r_item.bad, !mem_we)
    `LWSU_ASSERT_IMP(a_no_pop_busy, r_state != ST_FETCH, !o_pop)

endmodule

// ----- rtl/core/lattice_worm_soil_update.sv -----
// a result passes the queue slot, the registered lattice read and the output register
// one item at a time: registered lattice read, then write and result (held while the output
// stalls); a neighbour write follows when a worm moves, as the lattice has a single write port
// a 2-entry queue sits between the classifier and the lattice sequencer
// reset: control and config registers to defaults, queue and output empty; lattice not cleared
module lattice_worm_soil_update (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lwsu_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lwsu_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    lwsu_in_if.sink                          i_in,
    lwsu_out_if.source                       o_out
);
    import lwsu_pkg::*;

    t_item  front_item;
    t_item  head_item;
    logic   front_push;
    logic   q_ready;
    logic   q_valid;
    logic   back_pop;

    lwsu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_q_ready  (q_ready),
        .o_push     (front_push),
        .o_item     (front_item)
    );

    lwsu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_item  (front_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (head_item),
        .i_pop   (back_pop)
    );

    lwsu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_item  (head_item),
        .o_pop   (back_pop),
        .o_out   (o_out)
    );

endmodule
